[rtl/spcq_pkg.sv]
package spcq_pkg;

  // Divider: 1000000 fits in 20 bits, so the quotient takes 20 restoring steps.
  localparam int DIV_STEPS  = 20;
  localparam int MUL_STEPS  = 32;
  localparam int STEP_CNT_W = 5;
  localparam int CFG_ADDR_W = 4;

  localparam logic [DIV_STEPS-1:0] TICKS_PER_SEC = 20'd1000000;
  localparam logic [15:0]          RELOAD_MAX    = 16'hFFFF;

  // Input item kinds.
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_DRIVER = 2'd2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_HZ_PER_RPM   = 2'd0;
  localparam logic [1:0] REG_PULSES_PER_DEG = 2'd1;
  localparam logic [1:0] REG_INVERT       = 2'd2;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_NO_MOTION  = 3'd1,
    ST_ZERO_SPEED = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_PUSH   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_HZ,
    SQ_DIV,
    SQ_LDM,
    SQ_MUL,
    SQ_FIN
  } seq_state_t;

  typedef struct packed {
    logic        dir;
    logic [15:0] reload;
    logic [31:0] pulses;
  } train_t;

  typedef struct packed {
    logic load_div;
    logic load_mul;
    logic step;
    logic mode_mul;
  } arith_ctl_t;

endpackage

[rtl/spcq_if.sv]
interface spcq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        dir;
  logic [31:0] angle_q16;
  logic [15:0] req_rpm;
  logic        drv_status;

  modport source (output valid, kind, dir, angle_q16, req_rpm, drv_status,
                  input ready);
  modport sink   (input valid, kind, dir, angle_q16, req_rpm, drv_status,
                  output ready);
endinterface

interface spcq_out_if #(parameter int CNT_W = 5);
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             start_res;
  logic             dir_level;
  logic [15:0]      period_reload;
  logic [31:0]      pulse_count;
  logic             busy_res;
  logic [CNT_W-1:0] queue_count;
  logic [31:0]      overflow_total;
  logic             drive_enable;
  logic             brake_engaged;

  modport source (output valid, status, start_res, dir_level, period_reload, pulse_count,
                  busy_res, queue_count, overflow_total, drive_enable, brake_engaged,
                  input ready);
  modport sink   (input valid, status, start_res, dir_level, period_reload, pulse_count,
                  busy_res, queue_count, overflow_total, drive_enable, brake_engaged,
                  output ready);
endinterface

[rtl/step_pulse_command_queue.sv]
// Step/direction pulse-train command queue.
// in_ch carries one transaction per command or event: push (dir, angle,
// speed), train finished, or driver status. out_ch returns exactly one
// result transaction per input transaction, in order. Registers are set
// through the APB-style cfg_ port (hz per rpm, pulses per degree, invert)
// and must only be written while no transaction is in flight.
// Flow: a push with nonzero speed runs a 20-step restoring divide and a
// 32-step shift-add multiply on one shared 34-bit adder, after a state that
// registers hz and before the final step that registers its result. Every
// other transaction goes from acceptance straight to the final step.
// in_ch.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next transaction can be accepted while
// the receiver stalls. A new result then waits in its final step until the
// output register frees up.
// Reset (synchronous, active low) empties the queue, clears the residue and
// overflow count, disables the drive and engages the brake. Queue entries
// are not cleared; they are only read after being written.
module step_pulse_command_queue
  import spcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  spcq_in_if.sink               in_ch,
  spcq_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [15:0] hz_per_rpm_r;
  logic [31:0] ppd_r;
  logic        invert_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_per_rpm_r <= 16'd1;
      ppd_r        <= 32'd65536;
      invert_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HZ_PER_RPM:     hz_per_rpm_r <= cfg_pwdata[15:0];
        REG_PULSES_PER_DEG: ppd_r        <= cfg_pwdata;
        REG_INVERT:         invert_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HZ_PER_RPM:     cfg_prdata = {16'h0000, hz_per_rpm_r};
      REG_PULSES_PER_DEG: cfg_prdata = ppd_r;
      REG_INVERT:         cfg_prdata = {31'd0, invert_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Sequencer
  seq_state_t            state_r, state_nxt;
  logic [STEP_CNT_W-1:0] step_cnt_r, step_cnt_nxt;
  logic                  in_accept;
  logic                  out_free;
  logic                  fin_go;
  arith_ctl_t            actl;

  logic                  out_valid_r;

  assign in_accept = in_ch.valid & in_ch.ready;
  assign out_free  = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: begin
        if (in_accept) begin
          if (in_ch.kind == KIND_PUSH && in_ch.req_rpm != 16'd0) begin
            state_nxt = SQ_HZ;
          end else begin
            state_nxt = SQ_FIN;
          end
        end
      end
      SQ_HZ:  state_nxt = SQ_DIV;
      SQ_DIV: begin
        if (step_cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = SQ_LDM;
        end
      end
      SQ_LDM: state_nxt = SQ_MUL;
      SQ_MUL: begin
        if (step_cnt_r == STEP_CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = SQ_FIN;
        end
      end
      SQ_FIN: begin
        if (out_free) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    actl         = '0;
    fin_go       = 1'b0;
    step_cnt_nxt = '0;
    case (state_r)
      SQ_IDLE: in_ch.ready = 1'b1;
      SQ_HZ:   actl.load_div = 1'b1;
      SQ_DIV: begin
        actl.step    = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
      end
      SQ_LDM: begin
        actl.load_mul = 1'b1;
        actl.mode_mul = 1'b1;
      end
      SQ_MUL: begin
        actl.step     = 1'b1;
        actl.mode_mul = 1'b1;
        step_cnt_nxt  = step_cnt_r + 1'b1;
      end
      SQ_FIN:  fin_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= SQ_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  // Captured transaction
  logic [1:0]  kind_r;
  logic        dir_r;
  logic [31:0] angle_r;
  logic [15:0] rpm_r;
  logic        drv_ready_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r      <= in_ch.kind;
      dir_r       <= in_ch.dir;
      angle_r     <= in_ch.angle_q16;
      rpm_r       <= in_ch.req_rpm;
      drv_ready_r <= in_ch.drv_status;
    end
  end

  // Arithmetic: hz is registered in its own state, then divide and multiply on the shared unit
  logic [31:0]          hz_prod;
  logic [31:0]          hz_r;
  logic [DIV_STEPS-1:0] q_r;
  logic [DIV_STEPS-1:0] quotient;
  logic [63:0]          product;
  logic [15:0]          residue_r, residue_nxt;

  assign hz_prod = {16'h0000, rpm_r} * {16'h0000, hz_per_rpm_r};

  always_ff @(posedge clk) begin
    if (state_r == SQ_HZ) begin
      hz_r <= hz_prod;
    end
    if (state_r == SQ_LDM) begin
      q_r <= quotient;
    end
  end

  spcq_arith u_arith (
    .clk      (clk),
    .ctl      (actl),
    .hz       (hz_r),
    .ppd      (ppd_r),
    .angle    (angle_r),
    .residue  (residue_r),
    .quotient (quotient),
    .product  (product)
  );

  // Queue storage
  logic [PTR_W-1:0] wptr_r, wptr_nxt, wptr_inc;
  logic [PTR_W-1:0] rptr_r, rptr_nxt, rptr_inc;
  logic [CNT_W-1:0] qcnt_r, qcnt_nxt;
  logic             running_r, running_nxt;
  logic [31:0]      ovf_r, ovf_nxt;
  logic             enable_r, enable_nxt;
  logic             brake_r, brake_nxt;
  logic             mem_we;
  train_t           new_train, rd_train, launch_train;
  logic             launch;
  status_t          status_c;

  spcq_queue #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_queue (
    .clk     (clk),
    .wr_en   (mem_we & fin_go),
    .wr_addr (wptr_r),
    .wr_data (new_train),
    .rd_addr (rptr_r),
    .rd_data (rd_train)
  );

  assign wptr_inc = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;

  // Reload: clamp on zero hz, zero quotient (wraps) and anything above 16 bits
  logic [DIV_STEPS-1:0] reload_full;
  logic [15:0]          reload_val;

  always_comb begin
    reload_full = q_r - 1'b1;
    if (hz_r == 32'd0 || q_r == '0 || reload_full > DIV_STEPS'(RELOAD_MAX)) begin
      reload_val = RELOAD_MAX;
    end else begin
      reload_val = reload_full[15:0];
    end
  end

  assign new_train = '{dir: dir_r, reload: reload_val, pulses: product[63:32]};

  // Final step: decide the outcome and advance the queue state
  always_comb begin
    wptr_nxt     = wptr_r;
    rptr_nxt     = rptr_r;
    qcnt_nxt     = qcnt_r;
    running_nxt  = running_r;
    residue_nxt  = residue_r;
    ovf_nxt      = ovf_r;
    enable_nxt   = enable_r;
    brake_nxt    = brake_r;
    mem_we       = 1'b0;
    launch       = 1'b0;
    launch_train = new_train;
    status_c     = ST_NOT_PUSH;
    case (kind_r)
      KIND_PUSH: begin
        if (rpm_r == 16'd0) begin
          status_c = ST_ZERO_SPEED;
        end else if (product[63:32] == 32'd0) begin
          // Nothing to move; keep the fraction for the next command.
          residue_nxt = product[31:16];
          status_c    = ST_NO_MOTION;
        end else if (qcnt_r == CNT_W'(QUEUE_DEPTH)) begin
          ovf_nxt  = ovf_r + 1'b1;
          status_c = ST_FULL;
        end else begin
          residue_nxt = product[31:16];
          status_c    = ST_QUEUED;
          wptr_nxt    = wptr_inc;
          if (running_r) begin
            mem_we   = 1'b1;
            qcnt_nxt = qcnt_r + 1'b1;
          end else begin
            // Idle means the queue is empty: launch this train directly.
            rptr_nxt    = rptr_inc;
            running_nxt = 1'b1;
            launch      = 1'b1;
          end
        end
      end
      KIND_DONE: begin
        if (qcnt_r == '0) begin
          running_nxt = 1'b0;
        end else begin
          launch       = 1'b1;
          launch_train = rd_train;
          rptr_nxt     = rptr_inc;
          qcnt_nxt     = qcnt_r - 1'b1;
          running_nxt  = 1'b1;
        end
      end
      KIND_DRIVER: begin
        if (drv_ready_r) begin
          brake_nxt  = 1'b0;
          enable_nxt = 1'b1;
        end else begin
          // Fault: drop every queued train and the carried fraction.
          enable_nxt  = 1'b0;
          brake_nxt   = 1'b1;
          wptr_nxt    = '0;
          rptr_nxt    = '0;
          qcnt_nxt    = '0;
          running_nxt = 1'b0;
          residue_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r    <= '0;
      rptr_r    <= '0;
      qcnt_r    <= '0;
      running_r <= 1'b0;
      residue_r <= '0;
      ovf_r     <= '0;
      enable_r  <= 1'b0;
      brake_r   <= 1'b1;
    end else if (fin_go) begin
      wptr_r    <= wptr_nxt;
      rptr_r    <= rptr_nxt;
      qcnt_r    <= qcnt_nxt;
      running_r <= running_nxt;
      residue_r <= residue_nxt;
      ovf_r     <= ovf_nxt;
      enable_r  <= enable_nxt;
      brake_r   <= brake_nxt;
    end
  end

  // Output register
  status_t     res_status_r;
  logic        res_start_r;
  logic        res_dir_r;
  logic [15:0] res_reload_r;
  logic [31:0] res_pulses_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Launch fields read zero when no train starts.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_status_r <= status_c;
      res_start_r  <= launch;
      res_dir_r    <= launch & (launch_train.dir ^ invert_r);
      res_reload_r <= launch ? launch_train.reload : 16'd0;
      res_pulses_r <= launch ? launch_train.pulses : 32'd0;
    end
  end

  // Queue state only moves in the final step, which waits for a free
  // output register, so it stays matched to the pending result.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_status_r;
  assign out_ch.start_res      = res_start_r;
  assign out_ch.dir_level      = res_dir_r;
  assign out_ch.period_reload  = res_reload_r;
  assign out_ch.pulse_count    = res_pulses_r;
  assign out_ch.busy_res       = running_r;
  assign out_ch.queue_count    = qcnt_r;
  assign out_ch.overflow_total = ovf_r;
  assign out_ch.drive_enable   = enable_r;
  assign out_ch.brake_engaged  = brake_r;

endmodule

[rtl/spcq_arith.sv]
// Shared add/subtract unit with its shift registers: restoring divide of
// the tick constant by hz, then shift-add multiply of angle by ratio plus
// the residue offset.
module spcq_arith
  import spcq_pkg::*;
(
  input  logic                 clk,
  input  arith_ctl_t           ctl,
  input  logic [31:0]          hz,
  input  logic [31:0]          ppd,
  input  logic [31:0]          angle,
  input  logic [15:0]          residue,
  output logic [DIV_STEPS-1:0] quotient,
  output logic [63:0]          product
);

  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [33:0] op_a, op_b, sum;
  logic        borrow;
  logic [32:0] mul_t;

  always_comb begin
    op_a   = ctl.mode_mul ? {2'b00, hi_r} : {1'b0, hi_r, lo_r[31]};
    op_b   = {2'b00, (ctl.mode_mul ? ppd : hz)};
    sum    = op_a + (ctl.mode_mul ? op_b : ~op_b) + {33'd0, ~ctl.mode_mul};
    borrow = sum[33];
    mul_t  = lo_r[0] ? sum[32:0] : {1'b0, hi_r};

    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (ctl.load_div) begin
      hi_nxt = '0;
      lo_nxt = {TICKS_PER_SEC, {(32-DIV_STEPS){1'b0}}};
    end else if (ctl.load_mul) begin
      // Offset in the high half lands unshifted in the final product.
      hi_nxt = {residue, 16'h0000};
      lo_nxt = angle;
    end else if (ctl.step) begin
      if (ctl.mode_mul) begin
        hi_nxt = mul_t[32:1];
        lo_nxt = {mul_t[0], lo_r[31:1]};
      end else begin
        hi_nxt = borrow ? op_a[31:0] : sum[31:0];
        lo_nxt = {lo_r[30:0], ~borrow};
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign quotient = lo_r[DIV_STEPS-1:0];
  assign product  = {hi_r, lo_r};

endmodule

[rtl/spcq_queue.sv]
module spcq_queue
  import spcq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
)
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  train_t           wr_data,
  input  logic [PTR_W-1:0] rd_addr,
  output train_t           rd_data
);

  train_t mem [DEPTH];
  train_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/spcq_checker.sv]
module spcq_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = 5
)
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic             start_res,
  input logic             dir_level,
  input logic [15:0]      period_reload,
  input logic [31:0]      pulse_count,
  input logic             busy_res,
  input logic [CNT_W-1:0] queue_count,
  input logic             drive_enable,
  input logic             brake_engaged
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pulse_count)
      && $stable(queue_count))
    else $error("result changed while stalled");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && start_res |-> busy_res)
    else $error("launch without busy");

  a_no_launch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !start_res |-> dir_level == 1'b0 && period_reload == 16'd0
      && pulse_count == 32'd0)
    else $error("launch fields set without launch");

  a_brake_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> brake_engaged != drive_enable)
    else $error("brake and enable not complementary");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> queue_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

bind step_pulse_command_queue spcq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .CNT_W       (CNT_W)
) u_spcq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .start_res     (out_ch.start_res),
  .dir_level     (out_ch.dir_level),
  .period_reload (out_ch.period_reload),
  .pulse_count   (out_ch.pulse_count),
  .busy_res      (out_ch.busy_res),
  .queue_count   (out_ch.queue_count),
  .drive_enable  (out_ch.drive_enable),
  .brake_engaged (out_ch.brake_engaged)
);

[tb/sv/step_pulse_command_queue_checker.sv]
module step_pulse_command_queue_checker
  import spcq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spcq_in_if                    in_ch,
  spcq_out_if                   out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output int unsigned           fail_count,
  output int unsigned           results_due
);

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t     status;
    logic        start;
    logic        dir_level;
    logic [15:0] reload;
    logic [31:0] pulses;
    logic        busy;
    logic [4:0]  qcount;
    logic [31:0] overflow;
    logic        enable;
    logic        brake;
  } drive_result_t;

  // Register copies
  logic [15:0] hz_per_rpm;
  logic [31:0] pulses_per_deg;
  logic        invert_dir;

  // Queue and drive state
  train_t           trains [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   queued;
  logic             running;
  logic [15:0]      residue;
  logic [31:0]      overflow_cnt;
  logic             enable_lvl;
  logic             brake_lvl;

  drive_result_t result_now;
  drive_result_t results_q [$];
  int unsigned   mismatches;

  assign fail_count = mismatches;

  // Pop the next waiting train into result_now, or go idle.
  function void launch_train();
    if (queued == 0) begin
      running = 1'b0;
    end else begin
      result_now.start     = 1'b1;
      result_now.dir_level = trains[rd_ptr].dir ^ invert_dir;
      result_now.reload    = trains[rd_ptr].reload;
      result_now.pulses    = trains[rd_ptr].pulses;
      rd_ptr  = rd_ptr + 1'b1;
      queued  = queued - 1'b1;
      running = 1'b1;
    end
  endfunction

  function drive_result_t next_drive_result(input logic [1:0] kind, input logic dir,
                                            input logic [31:0] angle,
                                            input logic [15:0] rpm, input logic drv_ok);
    logic [31:0] rate;
    logic [31:0] quot;
    logic [31:0] quot_m1;
    logic [15:0] reload;
    logic [63:0] total;
    logic [31:0] pulses;
    logic [15:0] frac;
    result_now        = '0;
    result_now.status = ST_NOT_PUSH;
    case (kind)
      KIND_PUSH: begin
        if (rpm == 16'd0) begin
          result_now.status = ST_ZERO_SPEED;
        end else begin
          rate = {16'd0, rpm} * {16'd0, hz_per_rpm};
          if (rate == 32'd0) begin
            reload = RELOAD_MAX;
          end else begin
            quot    = {12'd0, TICKS_PER_SEC} / rate;
            quot_m1 = quot - 32'd1;
            reload  = (quot == 32'd0 || quot_m1 > {16'd0, RELOAD_MAX}) ? RELOAD_MAX
                                                                      : quot_m1[15:0];
          end
          total  = {32'd0, angle} * {32'd0, pulses_per_deg} + ({48'd0, residue} << 16);
          pulses = total[63:32];
          frac   = total[31:16];
          if (pulses == 32'd0) begin
            residue           = frac;
            result_now.status = ST_NO_MOTION;
          end else if (queued >= QUEUE_DEPTH) begin
            overflow_cnt      = overflow_cnt + 32'd1;
            result_now.status = ST_FULL;
          end else begin
            residue               = frac;
            trains[wr_ptr].dir    = dir;
            trains[wr_ptr].reload = reload;
            trains[wr_ptr].pulses = pulses;
            wr_ptr                = wr_ptr + 1'b1;
            queued                = queued + 1'b1;
            result_now.status     = ST_QUEUED;
            if (!running) launch_train();
          end
        end
      end
      KIND_DONE: launch_train();
      KIND_DRIVER: begin
        if (drv_ok) begin
          enable_lvl = 1'b1;
          brake_lvl  = 1'b0;
        end else begin
          enable_lvl = 1'b0;
          brake_lvl  = 1'b1;
          wr_ptr     = '0;
          rd_ptr     = '0;
          queued     = '0;
          running    = 1'b0;
          residue    = '0;
        end
      end
      default: ;
    endcase
    result_now.busy     = running;
    result_now.qcount   = 5'(queued);
    result_now.overflow = overflow_cnt;
    result_now.enable   = enable_lvl;
    result_now.brake    = brake_lvl;
    return result_now;
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t want;
    if (!rst_n) begin
      hz_per_rpm     = 16'd1;
      pulses_per_deg = 32'h0001_0000;
      invert_dir     = 1'b0;
      wr_ptr         = '0;
      rd_ptr         = '0;
      queued         = '0;
      running        = 1'b0;
      residue        = '0;
      overflow_cnt   = '0;
      enable_lvl     = 1'b0;
      brake_lvl      = 1'b1;
      results_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_HZ_PER_RPM:     hz_per_rpm     = cfg_pwdata[15:0];
          REG_PULSES_PER_DEG: pulses_per_deg = cfg_pwdata;
          REG_INVERT:         invert_dir     = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with nothing pending, status %0d", $time, out_ch.status);
          mismatches++;
        end else begin
          want = results_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("start_res", 32'(want.start), 32'(out_ch.start_res));
          check_field("dir_level", 32'(want.dir_level), 32'(out_ch.dir_level));
          check_field("period_reload", 32'(want.reload), 32'(out_ch.period_reload));
          check_field("pulse_count", want.pulses, out_ch.pulse_count);
          check_field("busy_res", 32'(want.busy), 32'(out_ch.busy_res));
          check_field("queue_count", 32'(want.qcount), 32'(out_ch.queue_count));
          check_field("overflow_total", want.overflow, out_ch.overflow_total);
          check_field("drive_enable", 32'(want.enable), 32'(out_ch.drive_enable));
          check_field("brake_engaged", 32'(want.brake), 32'(out_ch.brake_engaged));
        end
      end
      if (in_ch.valid && in_ch.ready)
        results_q.push_back(next_drive_result(in_ch.kind, in_ch.dir, in_ch.angle_q16,
                                              in_ch.req_rpm, in_ch.drv_status));
    end
    results_due <= results_q.size();
  end

endmodule

[tb/sv/step_pulse_command_queue_tb.sv]
module step_pulse_command_queue_tb;
  import spcq_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  // Slowest legal run is about 900 transactions plus one long hold;
  // allow roughly ten times that.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  // Extra wait at the end, longer than a push takes from acceptance to result.
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 140;
  localparam int CALM_ITEMS   = 50;

  // Kind code the block ignores, and a register slot with nothing behind it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned cycle_cnt;

  // calm: no idling on either side; hold_request: ask the receiver for one long stall.
  bit calm;
  bit hold_request;

  spcq_in_if               in_ch ();
  spcq_out_if #(.CNT_W(5)) out_ch ();

  step_pulse_command_queue #(.QUEUE_DEPTH(16)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  step_pulse_command_queue_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: count cycles and give up at the limit.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold on request, none when calm.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // APB write: setup phase, access phase, then an idle phase so back-to-back
  // writes never drive psel twice in the same step.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction and hold it until the block takes it. Valid stays
  // high into the next transaction unless a gap is drawn.
  task automatic send_item(input logic [1:0] kind, input logic dir, input logic [31:0] angle,
                           input logic [15:0] rpm, input logic drv_ok);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.dir        <= dir;
    in_ch.angle_q16  <= angle;
    in_ch.req_rpm    <= rpm;
    in_ch.drv_status <= drv_ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every pending result has been taken. The checker
  // count is registered, so the loop always advances the clock before testing it.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_config(input logic [15:0] hz, input logic [31:0] ppd, input logic inv);
    cfg_write(REG_HZ_PER_RPM, {16'd0, hz});
    cfg_write(REG_PULSES_PER_DEG, ppd);
    cfg_write(REG_INVERT, {31'd0, inv});
  endtask

  // Random traffic: mostly pushes and finished events, some driver reports and
  // the odd unused kind. Angles lean toward small values so fractions and
  // carries in the residue show up, with full-range values mixed in.
  task automatic send_random(input int count, input int push_w, input int done_w);
    int          n;
    int          pick;
    logic [1:0]  kind;
    logic [31:0] angle;
    logic [15:0] rpm;
    int          rpm_mode;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < push_w)               kind = KIND_PUSH;
      else if (pick < push_w + done_w) kind = KIND_DONE;
      else if (pick < 98)              kind = KIND_DRIVER;
      else                             kind = KIND_UNUSED;
      case ($urandom_range(0, 3))
        0:       angle = $urandom;
        1:       angle = $urandom_range(0, 32'h0000_FFFF);
        2:       angle = $urandom_range(0, 32'h003F_FFFF);
        default: angle = $urandom_range(0, 32'd360 << 16);
      endcase
      rpm_mode = $urandom_range(0, 19);
      if (rpm_mode == 0)      rpm = 16'd0;
      else if (rpm_mode < 10) rpm = 16'($urandom_range(1, 300));
      else                    rpm = 16'($urandom_range(1, 65535));
      send_item(kind, 1'($urandom_range(0, 1)), angle, rpm, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin : stimulus
    int          phase;
    logic [15:0] hz;
    logic [31:0] ppd;
    logic        inv;
    int          push_w;
    int          done_w;

    // Hold every input at a known level from time zero.
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_PUSH;
    in_ch.dir        <= 1'b0;
    in_ch.angle_q16  <= '0;
    in_ch.req_rpm    <= '0;
    in_ch.drv_status <= 1'b0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    calm             = 1'b0;
    hold_request     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration.
    send_item(KIND_DRIVER, 1'b0, '0, '0, 1'b1);                  // release brake
    send_item(KIND_PUSH, 1'b0, 32'd90 << 16, 16'd60, 1'b0);      // idle: launch at once
    send_item(KIND_PUSH, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);   // largest angle and speed
    send_item(KIND_PUSH, 1'b0, 32'd45 << 16, 16'd0, 1'b0);       // zero speed
    send_item(KIND_PUSH, 1'b0, 32'd0, 16'd1, 1'b0);              // no motion, slowest clamp
    send_item(KIND_PUSH, 1'b1, 32'h0000_8000, 16'd1, 1'b0);      // half degree: carried residue makes a pulse
    send_item(KIND_PUSH, 1'b0, 32'h0000_8000, 16'd1, 1'b0);      // half degree: residue only
    send_item(KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1); // ignored kind
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);                    // queue empty: go idle
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);                    // finished while idle
    send_item(KIND_PUSH, 1'b1, 32'd1 << 16, 16'hFFFF, 1'b0);
    send_item(KIND_PUSH, 1'b0, 32'd10 << 16, 16'd1000, 1'b0);
    send_item(KIND_DRIVER, 1'b0, '0, '0, 1'b0);                  // fault: flush everything
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);
    send_item(KIND_PUSH, 1'b0, 32'd5 << 16, 16'd100, 1'b0);
    send_item(KIND_DRIVER, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);

    // Extreme registers, inverted direction, and a write to the empty slot.
    drain_results();
    set_config(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(KIND_PUSH, 1'b0, 32'd1 << 16, 16'hFFFF, 1'b0);     // quotient zero
    send_item(KIND_PUSH, 1'b1, 32'd1 << 16, 16'd15, 1'b0);       // quotient one: reload 0
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);

    // Zero ratio: speed product is zero.
    drain_results();
    cfg_write(REG_HZ_PER_RPM, 32'd0);
    send_item(KIND_PUSH, 1'b1, 32'd3 << 16, 16'd1, 1'b0);
    send_item(KIND_DONE, 1'b0, '0, '0, 1'b0);

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          hz = 16'd1; ppd = 32'h0001_0000; inv = 1'b0; push_w = 60; done_w = 30;
        end
        1: begin
          hz = 16'hFFFF; ppd = 32'hFFFF_FFFF; inv = 1'b1; push_w = 75; done_w = 20;
        end
        2: begin
          hz = 16'd0; ppd = 32'd1; inv = 1'b0; push_w = 50; done_w = 40;
        end
        3: begin
          hz = 16'($urandom_range(1, 65535)); ppd = $urandom;
          inv = 1'($urandom_range(0, 1));
          push_w = 65; done_w = 30;
        end
        4: begin
          hz = 16'($urandom_range(1, 50)); ppd = $urandom_range(1, 32'h0008_0000);
          inv = 1'b1;
          push_w = 55; done_w = 40;
        end
        default: begin
          hz = 16'($urandom_range(1000, 65535)); ppd = $urandom_range(1, 32'h01F4_0000);
          inv = 1'b0; push_w = 70; done_w = 25;
        end
      endcase
      drain_results();
      set_config(hz, ppd, inv);
      send_item(KIND_DRIVER, 1'b0, '0, '0, 1'b1);
      // Push-heavy phase: stall the result side long enough to back up the block.
      if (phase == 1) hold_request = 1'b1;
      send_random(PHASE_ITEMS, push_w, done_w);
    end

    // Last stretch with no idling on either side.
    calm = 1'b1;
    send_random(CALM_ITEMS, 60, 35);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
